// ===== rtl/bdd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bdd_pkg: shared types and constants for the burst datagram deframer
// Holds the result kinds, status codes, parse phases and the queue entry type.
// ----------------------------------------------------------------------------
package bdd_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned HEADER_BYTES = 8;
  localparam int unsigned PREFIX_BYTES = 2;
  localparam logic [16:0] COUNT_MAX = 17'h1FFFF;
  localparam logic [15:0] MAX_PACKETS_RESET = 16'd32;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_EMPTY  = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TOO_SHORT  = 3'd1,
    ST_BAD_MAGIC  = 3'd2,
    ST_LEN_MISM   = 3'd3,
    ST_TOO_MANY   = 3'd4,
    ST_OVERRUN    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_LEN_HI = 2'd1,
    PH_LEN_LO = 2'd2,
    PH_DATA   = 2'd3
  } phase_t;

  // One queue entry: up to one packet result and one status result per byte
  typedef struct packed {
    logic        has_pkt;
    kind_t       pkt_kind;
    logic [7:0]  pkt_byte;
    logic [15:0] pkt_idx;
    logic        pkt_first;
    logic        pkt_last;
    logic        has_stat;
    status_t     stat;
    logic [15:0] stat_idx;
  } evt_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] pos);
    logic [7:0] m;
    unique case (pos)
      2'd0:    m = 8'hCA;
      2'd1:    m = 8'hFE;
      2'd2:    m = 8'hDE;
      default: m = 8'hCA;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/bdd_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bdd_in_if: datagram byte channel
// Valid/ready channel carrying one datagram byte and its end mark.
// ----------------------------------------------------------------------------
interface bdd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_datagram;

  modport source (output valid, output data_byte, output end_of_datagram, input ready);
  modport sink (input valid, input data_byte, input end_of_datagram, output ready);
endinterface
`default_nettype wire

// ===== rtl/bdd_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bdd_out_if: deframer result channel
// Valid/ready channel carrying one payload, empty-packet or status result.
// ----------------------------------------------------------------------------
interface bdd_out_if;
  logic             valid;
  logic             ready;
  bdd_pkg::kind_t   kind;
  logic [7:0]       payload_byte;
  logic [15:0]      packet_index;
  logic             packet_first;
  logic             packet_last;
  bdd_pkg::status_t status;
  logic             last_result;

  modport source (output valid, output kind, output payload_byte, output packet_index,
                  output packet_first, output packet_last, output status,
                  output last_result, input ready);
  modport sink (input valid, input kind, input payload_byte, input packet_index,
                input packet_first, input packet_last, input status,
                input last_result, output ready);
endinterface
`default_nettype wire

// ===== rtl/bdd_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bdd_front: header and packet parser
// Tracks the datagram framing per byte and pushes a result entry for each byte that yields a result.
// ----------------------------------------------------------------------------
module bdd_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  bdd_in_if.sink            in_chan,
  input  wire logic         cfg_we,
  input  wire logic [15:0]  cfg_wdata,
  input  wire logic         q_full,
  output logic              q_push,
  output bdd_pkg::evt_t     q_evt
);
  import bdd_pkg::*;

  logic [16:0] bc_r, bc_nxt;
  logic [15:0] tot_r, tot_nxt;
  logic [15:0] dpk_r, dpk_nxt;
  logic [15:0] pd_r, pd_nxt;
  logic [15:0] bl_r, bl_nxt;
  logic [16:0] pu_r, pu_nxt;
  logic [7:0]  lhb_r, lhb_nxt;
  phase_t      phase_r, phase_nxt;
  logic        magic_err_r, magic_err_nxt;
  logic        ovr_err_r, ovr_err_nxt;
  logic        fp_r, fp_nxt;
  logic [15:0] max_r;

  logic [7:0]  b;
  logic [15:0] len;
  logic [17:0] need;
  logic [15:0] bl_dec;
  logic        early;
  logic        accept;
  evt_t        evt;

  assign b      = in_chan.data_byte;
  assign accept = in_chan.valid && in_chan.ready;
  assign in_chan.ready = !q_full;
  assign q_push = accept && (evt.has_pkt || evt.has_stat);
  assign q_evt  = evt;

  always_comb begin
    bc_nxt        = (bc_r != COUNT_MAX) ? bc_r + 17'd1 : bc_r;
    tot_nxt       = tot_r;
    dpk_nxt       = dpk_r;
    pd_nxt        = pd_r;
    bl_nxt        = bl_r;
    pu_nxt        = pu_r;
    lhb_nxt       = lhb_r;
    phase_nxt     = phase_r;
    magic_err_nxt = magic_err_r;
    ovr_err_nxt   = ovr_err_r;
    fp_nxt        = fp_r;
    len           = {lhb_r, b};
    need          = {1'b0, pu_r} + 18'(PREFIX_BYTES) + {2'b00, len};
    bl_dec        = (bl_r != 16'd0) ? bl_r - 16'd1 : bl_r;
    evt           = '0;

    unique case (phase_r)
      PH_HEADER: begin
        if (bc_r < 17'd4) begin
          if (b != magic_byte(bc_r[1:0])) magic_err_nxt = 1'b1;
        end else if (bc_r == 17'd4 || bc_r == 17'd6) begin
          lhb_nxt = b;
        end else if (bc_r == 17'd5) begin
          tot_nxt = len;
        end else if (bc_r == 17'd7) begin
          dpk_nxt = len;
        end
        if (bc_r >= 17'(HEADER_BYTES - 1)) phase_nxt = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        if (pd_r < dpk_r) begin
          lhb_nxt   = b;
          phase_nxt = PH_LEN_LO;
        end
      end
      PH_LEN_LO: begin
        if ({1'b0, need} + 19'(HEADER_BYTES) > {3'b000, tot_r}) ovr_err_nxt = 1'b1;
        pu_nxt = (need > {1'b0, COUNT_MAX}) ? COUNT_MAX : need[16:0];
        if (len == 16'd0) begin
          evt.has_pkt   = 1'b1;
          evt.pkt_kind  = KIND_EMPTY;
          evt.pkt_idx   = pd_r;
          evt.pkt_first = 1'b1;
          evt.pkt_last  = 1'b1;
          pd_nxt        = pd_r + 16'd1;
          phase_nxt     = PH_LEN_HI;
        end else begin
          bl_nxt    = len;
          fp_nxt    = 1'b1;
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        evt.has_pkt   = 1'b1;
        evt.pkt_kind  = KIND_DATA;
        evt.pkt_byte  = b;
        evt.pkt_idx   = pd_r;
        evt.pkt_first = fp_r;
        evt.pkt_last  = (bl_r <= 16'd1);
        fp_nxt        = 1'b0;
        bl_nxt        = bl_dec;
        if (bl_dec == 16'd0) begin
          pd_nxt    = pd_r + 16'd1;
          phase_nxt = PH_LEN_HI;
        end
      end
    endcase

    // a datagram that stops inside the header or a packet, or before all counted packets, counts as overrun
    early = (phase_nxt != PH_LEN_HI) || (pd_nxt < dpk_nxt);

    evt.has_stat = in_chan.end_of_datagram;
    evt.stat_idx = pd_nxt;
    if (bc_nxt <= 17'(HEADER_BYTES))        evt.stat = ST_TOO_SHORT;
    else if (magic_err_nxt)                 evt.stat = ST_BAD_MAGIC;
    else if (bc_nxt != {1'b0, tot_nxt})     evt.stat = ST_LEN_MISM;
    else if (dpk_nxt > max_r)               evt.stat = ST_TOO_MANY;
    else if (ovr_err_nxt || early)          evt.stat = ST_OVERRUN;
    else                                    evt.stat = ST_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= MAX_PACKETS_RESET;
    end else if (cfg_we) begin
      max_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_chan.end_of_datagram)) begin
      bc_r        <= '0;
      tot_r       <= '0;
      dpk_r       <= '0;
      pd_r        <= '0;
      bl_r        <= '0;
      pu_r        <= '0;
      lhb_r       <= '0;
      phase_r     <= PH_HEADER;
      magic_err_r <= 1'b0;
      ovr_err_r   <= 1'b0;
      fp_r        <= 1'b0;
    end else if (accept) begin
      bc_r        <= bc_nxt;
      tot_r       <= tot_nxt;
      dpk_r       <= dpk_nxt;
      pd_r        <= pd_nxt;
      bl_r        <= bl_nxt;
      pu_r        <= pu_nxt;
      lhb_r       <= lhb_nxt;
      phase_r     <= phase_nxt;
      magic_err_r <= magic_err_nxt;
      ovr_err_r   <= ovr_err_nxt;
      fp_r        <= fp_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bdd_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bdd_queue: result entry queue
// Small circular buffer between the parser and the result sequencer.
// ----------------------------------------------------------------------------
module bdd_queue #(
  parameter int unsigned DEPTH = bdd_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire bdd_pkg::evt_t push_evt,
  output logic               full,
  input  wire logic          pop,
  output logic               head_valid,
  output bdd_pkg::evt_t      head_evt
);
  import bdd_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  evt_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  assign full       = (cnt_r == CW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_evt   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_evt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      if (pop)  rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      if (push && !pop)      cnt_r <= cnt_r + CW'(1);
      else if (pop && !push) cnt_r <= cnt_r - CW'(1);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bdd_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bdd_back: result sequencer
// Unpacks each queue entry into one or two results behind an output register.
// ----------------------------------------------------------------------------
module bdd_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire bdd_pkg::evt_t q_evt,
  output logic               q_pop,
  bdd_out_if.source          out_chan
);
  import bdd_pkg::*;

  logic        ov_r, ov_nxt;
  logic        pdone_r, pdone_nxt;
  kind_t       kind_r, kind_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic [15:0] idx_r, idx_nxt;
  logic        first_r, first_nxt;
  logic        lastp_r, lastp_nxt;
  status_t     stat_r, stat_nxt;
  logic        last_r, last_nxt;
  logic        load;
  logic        emit_pkt;

  assign load     = !ov_r || out_chan.ready;
  assign emit_pkt = q_evt.has_pkt && !pdone_r;

  always_comb begin
    ov_nxt    = ov_r;
    pdone_nxt = pdone_r;
    kind_nxt  = kind_r;
    byte_nxt  = byte_r;
    idx_nxt   = idx_r;
    first_nxt = first_r;
    lastp_nxt = lastp_r;
    stat_nxt  = stat_r;
    last_nxt  = last_r;
    q_pop     = 1'b0;
    if (load) begin
      ov_nxt = q_valid;
      if (q_valid) begin
        if (emit_pkt) begin
          kind_nxt  = q_evt.pkt_kind;
          byte_nxt  = q_evt.pkt_byte;
          idx_nxt   = q_evt.pkt_idx;
          first_nxt = q_evt.pkt_first;
          lastp_nxt = q_evt.pkt_last;
          stat_nxt  = ST_OK;
        end else begin
          kind_nxt  = KIND_STATUS;
          byte_nxt  = '0;
          idx_nxt   = q_evt.stat_idx;
          first_nxt = 1'b0;
          lastp_nxt = 1'b0;
          stat_nxt  = q_evt.stat;
        end
        // packet result followed by status: keep the entry one more transfer
        if (emit_pkt && q_evt.has_stat) begin
          pdone_nxt = 1'b1;
          last_nxt  = 1'b0;
        end else begin
          pdone_nxt = 1'b0;
          last_nxt  = 1'b1;
          q_pop     = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r    <= 1'b0;
      pdone_r <= 1'b0;
    end else begin
      ov_r    <= ov_nxt;
      pdone_r <= pdone_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    byte_r  <= byte_nxt;
    idx_r   <= idx_nxt;
    first_r <= first_nxt;
    lastp_r <= lastp_nxt;
    stat_r  <= stat_nxt;
    last_r  <= last_nxt;
  end

  assign out_chan.valid        = ov_r;
  assign out_chan.kind         = kind_r;
  assign out_chan.payload_byte = byte_r;
  assign out_chan.packet_index = idx_r;
  assign out_chan.packet_first = first_r;
  assign out_chan.packet_last  = lastp_r;
  assign out_chan.status       = stat_r;
  assign out_chan.last_result  = last_r;

`ifndef SYNTHESIS
  a_pop_needs_load: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> load && q_valid)
    else $error("queue popped without loading the output register");
  a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && kind_r == KIND_STATUS |-> last_r)
    else $error("status result not marked last");
  a_pending_entry: assert property (@(posedge clk) disable iff (!rst_n)
    pdone_r |-> q_valid && q_evt.has_stat)
    else $error("pending status lost its queue entry");
  a_status_follows: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !last_r && out_chan.ready |=> ov_r && kind_r == KIND_STATUS)
    else $error("non-final result not followed by status");
`endif

endmodule
`default_nettype wire

// ===== rtl/burst_datagram_deframer.sv =====
`default_nettype none
// Burst datagram deframer. Accepts one datagram byte per cycle whenever the
// internal result queue has room and hands out one result per cycle while the
// sink is ready. A byte causes at most two results (a payload or empty-packet
// result, then the status on the final byte), so a datagram's last byte can
// occupy two output transfers; the queue of QDEPTH entries between the parser
// and the output register absorbs that, and the sustained input rate is one
// byte per cycle as long as the sink takes one result per cycle. Results pass
// through the queue, then the output register. max_packets is written through
// cfg_we/cfg_wdata and should be changed only while no datagram is in flight.
// ----------------------------------------------------------------------------
// burst_datagram_deframer: top level
// Parser front end, result queue and result sequencer.
// ----------------------------------------------------------------------------
module burst_datagram_deframer #(
  parameter int unsigned QDEPTH = bdd_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  bdd_in_if.sink           in_chan,
  bdd_out_if.source        out_chan,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);
  import bdd_pkg::*;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_valid;
  evt_t push_evt;
  evt_t head_evt;

  bdd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_evt     (push_evt)
  );

  bdd_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_evt   (push_evt),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_evt   (head_evt)
  );

  bdd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_evt    (head_evt),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule
`default_nettype wire

// ===== tb/burst_datagram_deframer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// burst_datagram_deframer_tb: self-checking bench for the datagram deframer
// Feeds datagram bytes through a randomly stalled valid/ready channel. Each
// accepted byte is run through a software copy of the parser, and every output
// transfer is compared with the oldest predicted result. Well-formed and
// damaged datagrams are mixed across several max_packets settings.
// ----------------------------------------------------------------------------
module burst_datagram_deframer_tb;
  import bdd_pkg::*;

  localparam logic [31:0] MAGIC_WORD = 32'hCAFEDECA;
  localparam int unsigned IDLE_PCT   = 7;
  localparam int unsigned MAX_SHOWN  = 10;
  localparam longint unsigned TIMEOUT_NS = 64'd5_000_000;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic [15:0] packet_index;
    logic        packet_first;
    logic        packet_last;
    status_t     status;
    logic        last_result;
  } deframed_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       eod;
  } dg_byte_t;

  typedef enum int {
    DG_GOOD,
    DG_BAD_MAGIC,
    DG_BAD_TOTAL,
    DG_BAD_COUNT,
    DG_CUT_SHORT,
    DG_TOTAL_SHORT,
    DG_NOISE
  } dg_shape_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  bdd_in_if  in_if ();
  bdd_out_if out_if ();

  burst_datagram_deframer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  dg_byte_t    byte_q[$];
  deframed_t   deframed_q[$];
  int unsigned bytes_queued;
  int unsigned bytes_sent;
  int unsigned mismatches;
  bit          steady;

  // parser shadow state
  logic [15:0] p_max_packets;
  logic [16:0] p_count;
  logic [15:0] p_total;
  logic [15:0] p_npk;
  logic [15:0] p_done;
  logic [15:0] p_left;
  logic [16:0] p_used;
  logic [7:0]  p_hi;
  phase_t      p_phase;
  logic        p_bad_magic;
  logic        p_overrun;
  logic        p_first;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Verification failed");
    $finish;
  end

  function automatic void clear_datagram_state();
    p_count     = '0;
    p_total     = '0;
    p_npk       = '0;
    p_done      = '0;
    p_left      = '0;
    p_used      = '0;
    p_hi        = '0;
    p_phase     = PH_HEADER;
    p_bad_magic = 1'b0;
    p_overrun   = 1'b0;
    p_first     = 1'b0;
  endfunction

  function automatic deframed_t make_result(kind_t k, logic [7:0] b, logic [15:0] idx,
                                            logic f, logic l, status_t st);
    deframed_t r;
    r.kind         = k;
    r.payload_byte = b;
    r.packet_index = idx;
    r.packet_first = f;
    r.packet_last  = l;
    r.status       = st;
    r.last_result  = 1'b0;
    return r;
  endfunction

  function automatic string fmt_result(deframed_t r);
    return $sformatf("kind=%0d byte=%02h index=%0d first=%b last=%b status=%0d final=%b",
                     r.kind, r.payload_byte, r.packet_index, r.packet_first,
                     r.packet_last, r.status, r.last_result);
  endfunction

  // Advance the shadow parser by one byte and queue what it emits.
  function automatic void deframe_byte(input logic [7:0] b, input logic eod);
    deframed_t   res [2];
    int          n;
    logic [16:0] pos;
    logic [15:0] len;
    logic [31:0] mw;
    int unsigned need;
    logic        early;
    status_t     st;
    n   = 0;
    pos = p_count;
    if (p_count != COUNT_MAX) p_count = p_count + 17'd1;
    case (p_phase)
      PH_HEADER: begin
        if (pos < 4) begin
          mw = MAGIC_WORD >> (8 * (3 - pos[1:0]));
          if (b != mw[7:0]) p_bad_magic = 1'b1;
        end else if (pos == 4 || pos == 6) begin
          p_hi = b;
        end else if (pos == 5) begin
          p_total = {p_hi, b};
        end else if (pos == 7) begin
          p_npk = {p_hi, b};
        end
        if (pos + 1 >= HEADER_BYTES) p_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        // past the counted packets everything is ignored
        if (p_done < p_npk) begin
          p_hi    = b;
          p_phase = PH_LEN_LO;
        end
      end
      PH_LEN_LO: begin
        len  = {p_hi, b};
        need = p_used + PREFIX_BYTES + len;
        if (need + HEADER_BYTES > p_total) p_overrun = 1'b1;
        p_used = (need > COUNT_MAX) ? COUNT_MAX : need[16:0];
        if (len == 0) begin
          res[n] = make_result(KIND_EMPTY, 8'h00, p_done, 1'b1, 1'b1, ST_OK);
          n++;
          p_done++;
          p_phase = PH_LEN_HI;
        end else begin
          p_left  = len;
          p_first = 1'b1;
          p_phase = PH_DATA;
        end
      end
      default: begin
        res[n] = make_result(KIND_DATA, b, p_done, p_first, (p_left <= 1), ST_OK);
        n++;
        p_first = 1'b0;
        if (p_left > 0) p_left--;
        if (p_left == 0) begin
          p_done++;
          p_phase = PH_LEN_HI;
        end
      end
    endcase
    if (eod) begin
      early = (p_phase != PH_LEN_HI) || (p_done < p_npk);
      if (p_count <= HEADER_BYTES) st = ST_TOO_SHORT;
      else if (p_bad_magic) st = ST_BAD_MAGIC;
      else if (p_count != {1'b0, p_total}) st = ST_LEN_MISM;
      else if (p_npk > p_max_packets) st = ST_TOO_MANY;
      else if (p_overrun || early) st = ST_OVERRUN;
      else st = ST_OK;
      res[n] = make_result(KIND_STATUS, 8'h00, p_done, 1'b0, 1'b0, st);
      n++;
      clear_datagram_state();
    end
    if (n > 0) res[n-1].last_result = 1'b1;
    for (int i = 0; i < n; i++) deframed_q.push_back(res[i]);
  endfunction

  function automatic void push_byte(input logic [7:0] b, input logic eod);
    dg_byte_t x;
    x.data_byte = b;
    x.eod       = eod;
    byte_q.push_back(x);
    bytes_queued++;
  endfunction

  // Sends len bytes, most significant first; the last one closes the datagram.
  task automatic add_frame(input logic [127:0] bytes, input int len);
    for (int i = len - 1; i >= 0; i--) push_byte(bytes[8*i +: 8], (i == 0));
  endtask

  // Hold the sender until every transfer has gone through and all results are
  // back, then let the pipeline settle.
  task automatic drain();
    while (bytes_sent != bytes_queued || deframed_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max_packets(input logic [15:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we        <= 1'b0;
    p_max_packets = v;
  endtask

  // Queues random datagrams, mostly well-formed, until about n bytes are in.
  task automatic random_phase(input int unsigned n);
    logic [7:0]  body[$];
    int          npk;
    int          len;
    int          full;
    int          send;
    int          bit_i;
    int unsigned goal;
    logic [15:0] tot_f;
    logic [15:0] cnt_f;
    logic [31:0] mw;
    logic [63:0] hdr;
    dg_shape_t   shape;
    goal = bytes_queued + n;
    while (bytes_queued < goal) begin
      shape = ($urandom_range(0, 9) < 6) ? DG_GOOD : dg_shape_t'($urandom_range(1, 6));
      if (shape == DG_NOISE) begin
        send = $urandom_range(1, 12);
        for (int i = 0; i < send; i++)
          push_byte(8'($urandom_range(0, 255)), (i == send - 1));
      end else begin
        body.delete();
        npk = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
        for (int k = 0; k < npk; k++) begin
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
          body.push_back(len[15:8]);
          body.push_back(len[7:0]);
          for (int j = 0; j < len; j++) body.push_back(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) body.push_back(8'($urandom_range(0, 255)));
        end
        full  = 8 + body.size();
        send  = full;
        tot_f = 16'(full);
        cnt_f = 16'(npk);
        mw    = MAGIC_WORD;
        case (shape)
          DG_BAD_MAGIC: begin
            bit_i     = $urandom_range(0, 31);
            mw[bit_i] = ~mw[bit_i];
          end
          DG_BAD_TOTAL: begin
            case ($urandom_range(0, 2))
              0:       tot_f = 16'($urandom_range(0, 65535));
              1:       tot_f = 16'(full + $urandom_range(1, 3));
              default: tot_f = 16'(full - $urandom_range(1, 3));
            endcase
          end
          DG_BAD_COUNT: begin
            case ($urandom_range(0, 2))
              0:       cnt_f = 16'($urandom_range(0, 65535));
              1:       cnt_f = 16'(npk + $urandom_range(1, 2));
              default: cnt_f = (npk > 0) ? 16'(npk - 1) : 16'd1;
            endcase
          end
          DG_CUT_SHORT: send = $urandom_range(1, full - 1);
          DG_TOTAL_SHORT: begin
            // ends exactly at the declared total, before the full body
            if (full > 9) begin
              send  = $urandom_range(9, full - 1);
              tot_f = 16'(send);
            end
          end
          default: ;
        endcase
        hdr = {mw, tot_f, cnt_f};
        for (int i = 0; i < send; i++)
          push_byte((i < 8) ? hdr[8*(7-i) +: 8] : body[i-8], (i == send - 1));
      end
    end
  endtask

  // byte driver
  always @(posedge clk) begin
    dg_byte_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        deframe_byte(in_if.data_byte, in_if.end_of_datagram);
        bytes_sent++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (byte_q.size() > 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          nxt = byte_q.pop_front();
          in_if.valid           <= 1'b1;
          in_if.data_byte       <= nxt.data_byte;
          in_if.end_of_datagram <= nxt.eod;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    deframed_t want;
    deframed_t got;
    out_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    if (rst_n && out_if.valid && out_if.ready) begin
      got.kind         = out_if.kind;
      got.payload_byte = out_if.payload_byte;
      got.packet_index = out_if.packet_index;
      got.packet_first = out_if.packet_first;
      got.packet_last  = out_if.packet_last;
      got.status       = out_if.status;
      got.last_result  = out_if.last_result;
      if (deframed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("%0t: unexpected result: %s", $realtime, fmt_result(got));
      end else begin
        want = deframed_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN) begin
            $display("%0t: result mismatch, expected %s", $realtime, fmt_result(want));
            $display("%0t:                  actual   %s", $realtime, fmt_result(got));
          end
        end
      end
    end
  end

  initial begin
    clear_datagram_state();
    p_max_packets = MAX_PACKETS_RESET;
    steady        = 1'b0;
    bytes_queued  = 0;
    bytes_sent    = 0;
    mismatches    = 0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_if.valid           = 1'b0;
    in_if.data_byte       = '0;
    in_if.end_of_datagram = 1'b0;
    out_if.ready          = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // single-byte packet, last data byte also ends the datagram
    add_frame(88'hCAFEDECA_000B_0001_0001_FF, 11);
    // empty packet on the final byte
    add_frame(80'hCAFEDECA_000A_0001_0000, 10);
    add_frame(8'hFF, 1);
    // header only: still too short
    add_frame(64'hCAFEDECA_0008_0000, 8);
    // trailing byte after zero packets
    add_frame(72'hCAFEDECA_0009_0000_5A, 9);
    add_frame(72'hCAFEDECB_0009_0000_00, 9);
    add_frame(72'hCAFEDECA_0014_0000_00, 9);
    // 33 packets against the reset limit of 32
    add_frame(72'hCAFEDECA_0009_0021_00, 9);
    // packet runs past the declared total
    add_frame(96'hCAFEDECA_000C_0001_0005_0102, 12);
    // fits the total but the second packet never shows up
    add_frame(96'hCAFEDECA_000C_0002_0002_0102, 12);
    drain();

    write_max_packets(16'd0);
    random_phase(150);
    drain();

    write_max_packets(16'hFFFF);
    steady = 1'b1;
    random_phase(200);
    drain();
    steady = 1'b0;

    write_max_packets(16'($urandom_range(1, 6)));
    random_phase(200);
    drain();

    write_max_packets(16'($urandom_range(7, 40)));
    random_phase(200);
    drain();

    repeat (10) @(posedge clk);
    if (mismatches == 0 && deframed_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bdd_pkg.sv
rtl/bdd_in_if.sv
rtl/bdd_out_if.sv
rtl/bdd_front.sv
rtl/bdd_queue.sv
rtl/bdd_back.sv
rtl/burst_datagram_deframer.sv
tb/burst_datagram_deframer_tb.sv
